// File: sv/srsa_pkg.sv
// Shared types, codes and default sizes for the sparse row sorted accumulator.
package srsa_pkg;

    // Default sizes of the row store.
    localparam int MAX_ROWS_DEF = 256;
    localparam int ROW_CAP_DEF  = 128;

    // Request kinds carried in the slave-side tuser.
    localparam logic [1:0] REQ_SET  = 2'd0;
    localparam logic [1:0] REQ_ADD  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Result status codes carried in the master-side tuser.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    // Reset value of the dimension register.
    localparam logic [8:0] DIM_RESET = 9'd256;

    // One stored pair of a row: column in the low bits, Q16.16 value above.
    typedef struct packed {
        logic signed [31:0] value;
        logic [7:0]         col;
    } t_entry;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FILL,
        S_BINIT,
        S_BREQ,
        S_BCMP,
        S_PROBE,
        S_HIT,
        S_SHIFT,
        S_INSERT,
        S_DONE
    } t_state;

endpackage

// File: sv/srsa_ram.sv
// Generic single write port, single read port RAM with registered read data.
module srsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/sparse_row_sorted_accumulator_unit.sv
// Top level of the sparse row sorted accumulator: sequencer, search and insert datapath.
//
// Usage: each row of a square sparse matrix holds up to ROW_CAPACITY (column, value)
// pairs sorted by column. A request on the slave stream (s_*) sets, adds to or reads
// one element; the block answers with exactly one result on the master stream (m_*).
// The user must write the dimension register (i_cfg_we / i_cfg_wdata) only while idle;
// the block itself does not enforce this.
//
// Timing: the block takes one request at a time; s_tready is high only while idle.
// A request passes through setup (accept, row fill fetch, window load), a binary search
// over the row fill in up to ceil(log2(fill+1)) steps of entry read and compare,
// a probe and decide step, then for an insert a shift of each pair up one slot and
// the insert write, and last the load of the output register. The shared address adder
// and the single read port of the entry RAM keep these steps serial. An out-of-range
// request goes straight from accept to the output register load.
//
// Reset: i_rst_n is synchronous and active low. After reset the block sweeps the
// row fill counts to zero, one row per cycle, with s_tready low.
// Stall: the result sits in an output register. When m_tready is low the block
// still takes the next request and only waits at the end of that request's work.
module sparse_row_sorted_accumulator_unit #(
    parameter int MAX_ROWS     = srsa_pkg::MAX_ROWS_DEF,
    parameter int ROW_CAPACITY = srsa_pkg::ROW_CAP_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [7:0] row_index, [15:8] col_index, [47:16] value_in
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] read_value
    output logic [2:0]  m_tuser,   // [1:0] status, [2] was_present
    // Dimension register.
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata
);

    import srsa_pkg::*;

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW = $clog2(MAX_ROWS * ROW_CAPACITY);
    localparam int PW = $clog2(ROW_CAPACITY + 1);
    localparam int EW = $bits(t_entry);

    // Control state.
    t_state r_state, n_state;
    logic [RW-1:0] r_clr, n_clr;
    logic [8:0]    r_dim;
    logic          r_out_valid;

    // Request and working registers.
    logic [1:0]         r_req, n_req;
    logic [7:0]         r_row, n_row;
    logic [7:0]         r_col, n_col;
    logic signed [31:0] r_val, n_val;
    logic [AW-1:0]      r_base, n_base;
    logic [PW-1:0]      r_fill, n_fill;
    logic [PW-1:0]      r_lo, n_lo;
    logic [PW-1:0]      r_hi, n_hi;
    logic [PW-1:0]      r_mid, n_mid;
    logic [PW-1:0]      r_k, n_k;
    logic               r_wpend, n_wpend;
    logic [AW-1:0]      r_waddr, n_waddr;
    logic               r_hit, n_hit;
    logic signed [31:0] r_res_rd, n_res_rd;
    logic [1:0]         r_res_st, n_res_st;

    // Output register payload.
    logic signed [31:0] r_out_rd;
    logic [1:0]         r_out_st;
    logic               r_out_pres;

    // Request fields.
    logic [7:0] in_row;
    logic [7:0] in_col;
    logic       range_bad;

    // Memory ports.
    logic          fill_we;
    logic [RW-1:0] fill_waddr;
    logic [PW-1:0] fill_wdata;
    logic [PW-1:0] fill_rd;
    logic          ent_we;
    logic [AW-1:0] ent_waddr;
    t_entry        ent_wdata;
    logic [AW-1:0] ent_raddr;
    t_entry        ent_rd;
    logic [EW-1:0] ent_rd_bits;

    // Shared arithmetic.
    logic [PW-1:0]      mid_c;
    logic [PW-1:0]      addr_off;
    logic [AW-1:0]      addr_sum;
    logic               hit_c;
    logic signed [31:0] add_sum;
    logic signed [31:0] add_res;
    logic               add_ovf;
    logic               out_load;

    assign in_row = s_tdata[7:0];
    assign in_col = s_tdata[15:8];

    // A request is out of range when either index reaches the dimension or the row index reaches the row store.
    assign range_bad = ({1'b0, in_row} >= r_dim) || ({1'b0, in_col} >= r_dim)
                       || (32'(in_row) >= MAX_ROWS);

    // Midpoint of the current search window.
    assign mid_c = r_lo + ((r_hi - r_lo) >> 1);

    // Offset into the row for the entry RAM read address.
    always_comb begin
        case (r_state)
            S_BREQ:  addr_off = mid_c;
            S_SHIFT: addr_off = r_k - PW'(1);
            default: addr_off = r_lo;
        endcase
    end

    assign addr_sum = r_base + AW'(addr_off);

    assign ent_rd = t_entry'(ent_rd_bits);
    assign hit_c  = (r_lo < r_fill) && (ent_rd.col == r_col);

    // Saturating add of the stored value and the request value.
    assign add_sum = ent_rd.value + r_val;
    assign add_ovf = (ent_rd.value[31] == r_val[31]) && (add_sum[31] != ent_rd.value[31]);
    assign add_res = add_ovf ? (ent_rd.value[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                             : add_sum;

    assign out_load = (r_state == S_DONE) && (!r_out_valid || m_tready);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == RW'(MAX_ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    n_state = range_bad ? S_DONE : S_FILL;
                end
            end
            S_FILL:  n_state = S_BINIT;
            S_BINIT: n_state = S_BREQ;
            S_BREQ:  n_state = (r_lo < r_hi) ? S_BCMP : S_PROBE;
            S_BCMP:  n_state = S_BREQ;
            S_PROBE: n_state = S_HIT;
            S_HIT: begin
                if (r_req inside {REQ_SET, REQ_ADD} && !hit_c
                        && (r_fill < PW'(ROW_CAPACITY))) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (!(r_k > r_lo)) begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake and memory controls.
    always_comb begin
        s_tready   = (r_state == S_IDLE);
        fill_we    = 1'b0;
        fill_waddr = RW'(r_row);
        fill_wdata = r_fill + PW'(1);
        ent_we     = 1'b0;
        ent_waddr  = addr_sum;
        ent_wdata  = '{value: r_val, col: r_col};
        ent_raddr  = addr_sum;
        case (r_state)
            S_CLEAR: begin
                fill_we    = 1'b1;
                fill_waddr = r_clr;
                fill_wdata = '0;
            end
            S_HIT: begin
                if (hit_c && r_req inside {REQ_SET, REQ_ADD}) begin
                    ent_we = 1'b1;
                    if (r_req == REQ_ADD) begin
                        ent_wdata.value = add_res;
                    end
                end
            end
            S_SHIFT: begin
                ent_we    = r_wpend;
                ent_waddr = r_waddr;
                ent_wdata = ent_rd;
            end
            S_INSERT: begin
                ent_we  = 1'b1;
                fill_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_clr    = r_clr;
        n_req    = r_req;
        n_row    = r_row;
        n_col    = r_col;
        n_val    = r_val;
        n_base   = r_base;
        n_fill   = r_fill;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_k      = r_k;
        n_wpend  = r_wpend;
        n_waddr  = r_waddr;
        n_hit    = r_hit;
        n_res_rd = r_res_rd;
        n_res_st = r_res_st;
        case (r_state)
            S_CLEAR: n_clr = r_clr + RW'(1);
            S_IDLE: begin
                if (s_tvalid) begin
                    n_req    = s_tuser;
                    n_row    = in_row;
                    n_col    = in_col;
                    n_val    = s_tdata[47:16];
                    n_hit    = 1'b0;
                    n_res_rd = '0;
                    n_res_st = range_bad ? ST_RANGE : ST_OK;
                end
            end
            S_FILL: n_base = AW'(r_row) * AW'(ROW_CAPACITY);
            S_BINIT: begin
                n_fill = fill_rd;
                n_lo   = '0;
                n_hi   = fill_rd;
            end
            S_BREQ: n_mid = mid_c;
            S_BCMP: begin
                // Narrow the window toward the first column not below the request.
                if (ent_rd.col < r_col) begin
                    n_lo = r_mid + PW'(1);
                end else begin
                    n_hi = r_mid;
                end
            end
            S_HIT: begin
                n_hit = hit_c;
                if (!(r_req inside {REQ_SET, REQ_ADD})) begin
                    n_res_rd = hit_c ? ent_rd.value : 32'sd0;
                end else if (hit_c) begin
                    n_res_st = ((r_req == REQ_ADD) && add_ovf) ? ST_SAT : ST_OK;
                end else if (r_fill >= PW'(ROW_CAPACITY)) begin
                    n_res_st = ST_FULL;
                end else begin
                    n_k     = r_fill;
                    n_wpend = 1'b0;
                end
            end
            S_SHIFT: begin
                // Move one pair up per cycle, from the end of the row down to the slot.
                if (r_k > r_lo) begin
                    n_k     = r_k - PW'(1);
                    n_wpend = 1'b1;
                    n_waddr = addr_sum + AW'(1);
                end else begin
                    n_wpend = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_dim       <= DIM_RESET;
            r_out_valid <= 1'b0;
            r_wpend     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_wpend <= n_wpend;
            if (i_cfg_we) begin
                r_dim <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_row    <= n_row;
        r_col    <= n_col;
        r_val    <= n_val;
        r_base   <= n_base;
        r_fill   <= n_fill;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_k      <= n_k;
        r_waddr  <= n_waddr;
        r_hit    <= n_hit;
        r_res_rd <= n_res_rd;
        r_res_st <= n_res_st;
        if (out_load) begin
            r_out_rd   <= r_res_rd;
            r_out_st   <= r_res_st;
            r_out_pres <= r_hit;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_rd;
    assign m_tuser  = {r_out_pres, r_out_st};

    // Row fill counts.
    srsa_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_ROWS)
    ) u_fill_ram (
        .i_clk     (i_clk),
        .i_wr_en   (fill_we),
        .i_wr_addr (fill_waddr),
        .i_wr_data (fill_wdata),
        .i_rd_addr (RW'(r_row)),
        .o_rd_data (fill_rd)
    );

    // Column and value pairs of all rows.
    srsa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ROWS * ROW_CAPACITY)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ent_we),
        .i_wr_addr (ent_waddr),
        .i_wr_data (EW'(ent_wdata)),
        .i_rd_addr (ent_raddr),
        .o_rd_data (ent_rd_bits)
    );

endmodule

// File: sv/srsa_checker.sv
// Port-level checks for the sparse row sorted accumulator, bound to the top level.
module srsa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    import srsa_pkg::*;

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // The block takes one request at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // A nonzero value only comes from a successful read of a present element.
    a_value_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata != 32'd0) |-> m_tuser[2] && (m_tuser[1:0] == ST_OK))
        else $error("nonzero value without a present element");

    // Saturation only happens on an add that hit, and returns no value.
    a_sat_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser[1:0] == ST_SAT) |-> m_tuser[2] && (m_tdata == 32'd0))
        else $error("saturation without a present element");

    // Range and row-full results never report a present element.
    a_err_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && ((m_tuser[1:0] == ST_RANGE) || (m_tuser[1:0] == ST_FULL))
        |-> !m_tuser[2] && (m_tdata == 32'd0))
        else $error("error result reports a present element");

endmodule

bind sparse_row_sorted_accumulator_unit srsa_checker u_srsa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
